// ===== hw/rtl/tdh_pkg.sv =====
// ============================================================================
// tdh_pkg: shared types and constants for the token de-duplication hash set
// Holds the controller state type and the fixed field widths used by the
// top level and by the iterative modulo unit.
// ============================================================================
package tdh_pkg;

   // Width of the table_size register and of the distinct counter.
   localparam int SIZE_W     = 11;
   // Width of the index returned with each result.
   localparam int IDX_W      = 10;
   // Width of the batch epoch tag kept with each slot.
   localparam int EPOCH_W    = 8;
   // Width of the folded hash.
   localparam int HASH_W     = 32;
   // Hash bits retired per cycle by the modulo unit.
   localparam int DIV_BITS   = 4;
   localparam int DIV_STEPS  = HASH_W / DIV_BITS;
   localparam int DIV_STEP_W = $clog2(DIV_STEPS);

   // Controller states of the top level.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_READ,
      ST_CHECK
   } state_type;

endpackage

// ===== hw/rtl/token_dedup_hash_set.sv =====
// ============================================================================
// token_dedup_hash_set: batch-wise de-duplication of 128-bit tokens
// Open-addressing hash set with linear probing, held in one slot RAM that
// stores key, batch epoch tag and first-seen index for each slot.
// ============================================================================
// Each accepted token passes the states DIV_GO, DIV_WAIT (the iterative
// hash-modulo unit), READ and CHECK; CHECK probes one slot per cycle until
// a free slot, a match or the last slot of the table ends the probe.
// No new transaction is taken before the result; the result cannot be stalled.
// Reset: synchronous; afterwards busy stays high while the slot RAM is
// swept clear. Every 255th start_batch repeats that sweep.
module token_dedup_hash_set #(
   parameter int TABLE_DEPTH = 1024,
   parameter int TOKEN_BYTES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [63:0]                   req_token_low,
   input  logic [63:0]                   req_token_high,
   input  logic                          req_start_batch,
   output logic                          rsp_valid,
   output logic                          rsp_is_new,
   output logic [tdh_pkg::IDX_W-1:0]     rsp_first_index,
   output logic                          rsp_table_full,
   input  logic                          csr_wr_en,
   input  logic [tdh_pkg::SIZE_W-1:0]    csr_wr_data
);

   localparam int AW       = $clog2(TABLE_DEPTH);
   localparam int KEY_W    = 8 * TOKEN_BYTES;
   localparam int ENTRY_W  = KEY_W + tdh_pkg::EPOCH_W + tdh_pkg::IDX_W;
   localparam int LO_BYTES = (TOKEN_BYTES > 8) ? 8 : TOKEN_BYTES;
   localparam int HI_BYTES = (TOKEN_BYTES > 8) ? TOKEN_BYTES - 8 : 0;
   localparam logic [63:0] LO_MASK =
      (LO_BYTES == 8) ? {64{1'b1}} : ((64'd1 << (8 * LO_BYTES)) - 64'd1);
   localparam logic [63:0] HI_MASK =
      (HI_BYTES == 8) ? {64{1'b1}} : ((64'd1 << (8 * HI_BYTES)) - 64'd1);
   localparam logic [tdh_pkg::EPOCH_W-1:0] EPOCH_LAST  = {tdh_pkg::EPOCH_W{1'b1}};
   localparam logic [tdh_pkg::EPOCH_W-1:0] EPOCH_FIRST = tdh_pkg::EPOCH_W'(1);
   localparam logic [AW-1:0]               SWEEP_LAST  = AW'(TABLE_DEPTH - 1);

   tdh_pkg::state_type state_ff, state_in;

   logic [tdh_pkg::SIZE_W-1:0]  csr_size_ff, csr_size_in;
   logic [tdh_pkg::SIZE_W-1:0]  size_eff;
   logic [tdh_pkg::SIZE_W-1:0]  size_ff, size_in;
   logic [tdh_pkg::EPOCH_W-1:0] epoch_ff, epoch_in;
   logic [tdh_pkg::SIZE_W-1:0]  count_ff, count_in;
   logic                        pending_ff, pending_in;
   logic [AW-1:0]               sweep_ff, sweep_in;
   logic [KEY_W-1:0]            key_ff, key_in;
   logic [tdh_pkg::HASH_W-1:0]  hash_ff, hash_in;
   logic [tdh_pkg::SIZE_W-1:0]  idx_ff, idx_in;
   logic [tdh_pkg::SIZE_W-1:0]  idx_next;
   logic [tdh_pkg::SIZE_W-1:0]  probes_ff, probes_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_is_new_ff, rsp_is_new_in;
   logic [tdh_pkg::IDX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic                        rsp_full_ff, rsp_full_in;

   logic [63:0]                 token_lo_m, token_hi_m;
   logic [127:0]                token_m;
   logic                        accept;

   logic                        ram_we;
   logic [AW-1:0]               ram_waddr, ram_raddr;
   logic [ENTRY_W-1:0]          ram_wdata, ram_rdata;
   logic [KEY_W-1:0]            rd_key;
   logic [tdh_pkg::EPOCH_W-1:0] rd_tag;
   logic [tdh_pkg::IDX_W-1:0]   rd_index;
   logic                        slot_live, key_match, probe_last;

   logic                        div_start, div_done;
   logic [tdh_pkg::SIZE_W-1:0]  div_rem;

   // Mask bytes past the token length; the hash folds the four 32-bit words.
   assign token_lo_m = req_token_low & LO_MASK;
   assign token_hi_m = req_token_high & HI_MASK;
   assign token_m    = {token_hi_m, token_lo_m};
   assign accept     = start && !busy;

   // Slots in use: zero counts as one, and the RAM depth caps the register.
   always_comb begin
      if (csr_size_ff == '0) begin
         size_eff = tdh_pkg::SIZE_W'(1);
      end else if (32'(csr_size_ff) > 32'(TABLE_DEPTH)) begin
         size_eff = tdh_pkg::SIZE_W'(TABLE_DEPTH);
      end else begin
         size_eff = csr_size_ff;
      end
   end

   // Fields of the slot entry returned by the RAM.
   assign rd_key     = ram_rdata[ENTRY_W-1 -: KEY_W];
   assign rd_tag     = ram_rdata[tdh_pkg::IDX_W +: tdh_pkg::EPOCH_W];
   assign rd_index   = ram_rdata[tdh_pkg::IDX_W-1:0];
   assign slot_live  = (rd_tag == epoch_ff);
   assign key_match  = (rd_key == key_ff);
   assign probe_last = (probes_ff == size_ff - 1'b1);
   assign idx_next   = (idx_ff == size_ff - 1'b1) ? '0 : idx_ff + 1'b1;

   // Next-state logic of the controller.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tdh_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_start_batch && epoch_ff == EPOCH_LAST) begin
                  state_in = tdh_pkg::ST_CLEAR;
               end else begin
                  state_in = tdh_pkg::ST_DIV_GO;
               end
            end
         end
         tdh_pkg::ST_CLEAR: begin
            if (sweep_ff == SWEEP_LAST) begin
               state_in = pending_ff ? tdh_pkg::ST_DIV_GO : tdh_pkg::ST_IDLE;
            end
         end
         tdh_pkg::ST_DIV_GO: begin
            state_in = tdh_pkg::ST_DIV_WAIT;
         end
         tdh_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = tdh_pkg::ST_READ;
            end
         end
         tdh_pkg::ST_READ: begin
            state_in = tdh_pkg::ST_CHECK;
         end
         tdh_pkg::ST_CHECK: begin
            if (!slot_live || key_match || probe_last) begin
               state_in = tdh_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tdh_pkg::ST_IDLE;
         end
      endcase
   end

   // Controller outputs: handshake, RAM port and modulo unit start.
   always_comb begin
      busy      = 1'b1;
      ram_we    = 1'b0;
      ram_waddr = AW'(idx_ff);
      ram_wdata = {key_ff, epoch_ff, count_ff[tdh_pkg::IDX_W-1:0]};
      ram_raddr = AW'(idx_ff);
      div_start = 1'b0;
      case (state_ff)
         tdh_pkg::ST_IDLE: begin
            busy = 1'b0;
         end
         tdh_pkg::ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = sweep_ff;
            ram_wdata = '0;
         end
         tdh_pkg::ST_DIV_GO: begin
            div_start = 1'b1;
         end
         tdh_pkg::ST_CHECK: begin
            // The next slot is read ahead so a miss probes one slot per cycle.
            ram_raddr = AW'(idx_next);
            ram_we    = !slot_live;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   // Datapath registers: batch state, probe position and result.
   always_comb begin
      csr_size_in   = csr_wr_en ? csr_wr_data : csr_size_ff;
      size_in       = size_ff;
      epoch_in      = epoch_ff;
      count_in      = count_ff;
      pending_in    = pending_ff;
      sweep_in      = sweep_ff;
      key_in        = key_ff;
      hash_in       = hash_ff;
      idx_in        = idx_ff;
      probes_in     = probes_ff;
      rsp_valid_in  = 1'b0;
      rsp_is_new_in = rsp_is_new_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_full_in   = rsp_full_ff;
      case (state_ff)
         tdh_pkg::ST_IDLE: begin
            if (accept) begin
               pending_in = 1'b1;
               size_in    = size_eff;
               key_in     = token_m[KEY_W-1:0];
               hash_in    = token_lo_m[31:0] ^ token_lo_m[63:32] ^
                            token_hi_m[31:0] ^ token_hi_m[63:32];
               sweep_in   = '0;
               // A new batch takes a fresh epoch; the last epoch forces a sweep.
               if (req_start_batch && epoch_ff != EPOCH_LAST) begin
                  epoch_in = epoch_ff + 1'b1;
                  count_in = '0;
               end
            end
         end
         tdh_pkg::ST_CLEAR: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == SWEEP_LAST) begin
               epoch_in = EPOCH_FIRST;
               count_in = '0;
            end
         end
         tdh_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               idx_in    = div_rem;
               probes_in = '0;
            end
         end
         tdh_pkg::ST_CHECK: begin
            if (!slot_live) begin
               // Empty slot for this batch: store the token with a new index.
               rsp_valid_in  = 1'b1;
               rsp_is_new_in = 1'b1;
               rsp_index_in  = count_ff[tdh_pkg::IDX_W-1:0];
               rsp_full_in   = 1'b0;
               count_in      = count_ff + 1'b1;
               pending_in    = 1'b0;
            end else if (key_match) begin
               rsp_valid_in  = 1'b1;
               rsp_is_new_in = 1'b0;
               rsp_index_in  = rd_index;
               rsp_full_in   = 1'b0;
               pending_in    = 1'b0;
            end else if (probe_last) begin
               rsp_valid_in  = 1'b1;
               rsp_is_new_in = 1'b0;
               rsp_index_in  = '0;
               rsp_full_in   = 1'b1;
               pending_in    = 1'b0;
            end else begin
               idx_in    = idx_next;
               probes_in = probes_ff + 1'b1;
            end
         end
         default: begin
            pending_in = pending_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tdh_pkg::ST_CLEAR;
         csr_size_ff  <= tdh_pkg::SIZE_W'(1024);
         epoch_ff     <= '0;
         count_ff     <= '0;
         pending_ff   <= 1'b0;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         csr_size_ff  <= csr_size_in;
         epoch_ff     <= epoch_in;
         count_ff     <= count_in;
         pending_ff   <= pending_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      size_ff       <= size_in;
      key_ff        <= key_in;
      hash_ff       <= hash_in;
      idx_ff        <= idx_in;
      probes_ff     <= probes_in;
      rsp_is_new_ff <= rsp_is_new_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_full_ff   <= rsp_full_in;
   end

   // Slot RAM: key, epoch tag and first-seen index per slot.
   tdh_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Hash modulo the table size gives the first slot of the probe.
   tdh_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (hash_ff),
      .divisor   (size_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_is_new      = rsp_is_new_ff;
   assign rsp_first_index = rsp_index_ff;
   assign rsp_table_full  = rsp_full_ff;

endmodule

// ===== hw/rtl/tdh_ram.sv =====
// ============================================================================
// tdh_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one read per cycle; read data is registered.
// ============================================================================
module tdh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/tdh_mod.sv =====
// ============================================================================
// tdh_mod: iterative remainder unit for the hash
// Computes a 32-bit dividend modulo an 11-bit divisor by restoring division,
// four dividend bits per cycle.
// ============================================================================
module tdh_mod (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [tdh_pkg::HASH_W-1:0] dividend,
   input  logic [tdh_pkg::SIZE_W-1:0] divisor,
   output logic                      done,
   output logic [tdh_pkg::SIZE_W-1:0] remainder
);

   logic                          run_ff, run_in;
   logic                          done_ff, done_in;
   logic [tdh_pkg::DIV_STEP_W-1:0] step_ff, step_in;
   logic [tdh_pkg::HASH_W-1:0]     num_ff, num_in;
   logic [tdh_pkg::SIZE_W-1:0]     rem_ff, rem_in;
   logic [tdh_pkg::SIZE_W-1:0]     div_ff, div_in;
   logic [tdh_pkg::SIZE_W:0]       partial;

   // Four restoring steps on the running remainder, most significant bit first.
   always_comb begin
      logic [tdh_pkg::SIZE_W:0] trial;
      partial = {1'b0, rem_ff};
      for (int k = 0; k < tdh_pkg::DIV_BITS; k++) begin
         trial = {partial[tdh_pkg::SIZE_W-1:0], num_ff[tdh_pkg::HASH_W-1-k]};
         if (trial >= {1'b0, div_ff}) begin
            partial = trial - {1'b0, div_ff};
         end else begin
            partial = trial;
         end
      end
   end

   // Next values of the iteration registers.
   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         run_in  = 1'b1;
         step_in = '0;
         num_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (run_ff) begin
         rem_in  = partial[tdh_pkg::SIZE_W-1:0];
         num_in  = num_ff << tdh_pkg::DIV_BITS;
         step_in = step_ff + 1'b1;
         if (step_ff == tdh_pkg::DIV_STEP_W'(tdh_pkg::DIV_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== dv/token_dedup_hash_set_check.sv =====
// ============================================================================
// token_dedup_hash_set_check: result checker for the token de-duplication set
// Watches the command, result and register ports of the block, keeps its own
// copy of the hash set, predicts the result of every accepted transaction and
// compares each result strobe, field by field, with the oldest prediction.
// ============================================================================
`timescale 1ns / 1ps

module token_dedup_hash_set_check #(
   parameter int TABLE_DEPTH = 1024,
   parameter int TOKEN_BYTES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic [63:0]                   req_token_low,
   input  logic [63:0]                   req_token_high,
   input  logic                          req_start_batch,
   input  logic                          rsp_valid,
   input  logic                          rsp_is_new,
   input  logic [tdh_pkg::IDX_W-1:0]     rsp_first_index,
   input  logic                          rsp_table_full,
   input  logic                          csr_wr_en,
   input  logic [tdh_pkg::SIZE_W-1:0]    csr_wr_data,
   output int                            error_count,
   output int                            pending_count
);

   // Token bytes beyond TOKEN_BYTES never take part in hashing or matching.
   localparam logic [63:0] LOW_MASK = (TOKEN_BYTES >= 8) ? {64{1'b1}} :
                                      ((64'd1 << (8 * TOKEN_BYTES)) - 64'd1);
   localparam logic [63:0] HIGH_MASK = (TOKEN_BYTES >= 16) ? {64{1'b1}} :
                                       (TOKEN_BYTES <= 8) ? 64'd0 :
                                       ((64'd1 << (8 * (TOKEN_BYTES - 8))) - 64'd1);
   localparam int MAX_PRINTED = 100;

   typedef struct packed {
      logic                      is_new;
      logic [tdh_pkg::IDX_W-1:0] first_index;
      logic                      table_full;
   } lookup_result_type;

   // Shadow copy of the hash set and of the size register.
   logic [63:0]                stored_low  [TABLE_DEPTH];
   logic [63:0]                stored_high [TABLE_DEPTH];
   logic                       slot_used   [TABLE_DEPTH];
   logic [tdh_pkg::SIZE_W-1:0] slot_index  [TABLE_DEPTH];
   logic [tdh_pkg::SIZE_W-1:0] distinct_count;
   logic [tdh_pkg::SIZE_W-1:0] table_size;

   // Predicted results, oldest first.
   lookup_result_type expected_results[$];

   // Looks the token up in the shadow set, inserting it when a free slot
   // comes first on the linear probe.
   function automatic lookup_result_type insert_token(input logic [63:0] low_in,
                                                      input logic [63:0] high_in,
                                                      input logic new_batch);
      logic [63:0]       low;
      logic [63:0]       high;
      logic [31:0]       hash;
      int                size;
      int                slot;
      lookup_result_type res;
      low  = low_in & LOW_MASK;
      high = high_in & HIGH_MASK;
      if (new_batch) begin
         foreach (slot_used[i]) slot_used[i] = 1'b0;
         distinct_count = '0;
      end
      // A size of zero acts as one, anything above the depth as the depth.
      size = (table_size == 0) ? 1 : ((table_size > TABLE_DEPTH) ? TABLE_DEPTH :
                                      int'(table_size));
      hash = low[31:0] ^ low[63:32] ^ high[31:0] ^ high[63:32];
      slot = int'(hash % size);
      // Nothing found and no free slot: the table is full.
      res = '0;
      res.table_full = 1'b1;
      for (int n = 0; n < size; n++) begin
         if (!slot_used[slot]) begin
            stored_low[slot]  = low;
            stored_high[slot] = high;
            slot_used[slot]   = 1'b1;
            slot_index[slot]  = distinct_count;
            res.is_new        = 1'b1;
            res.first_index   = distinct_count[tdh_pkg::IDX_W-1:0];
            res.table_full    = 1'b0;
            distinct_count    = distinct_count + 1'b1;
            return res;
         end
         if (stored_low[slot] == low && stored_high[slot] == high) begin
            res.first_index = slot_index[slot][tdh_pkg::IDX_W-1:0];
            res.table_full  = 1'b0;
            return res;
         end
         slot = (slot + 1 == size) ? 0 : slot + 1;
      end
      return res;
   endfunction

   // Prints one line per mismatch, up to a cap, and counts every one.
   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= MAX_PRINTED) $display("%0t ns: mismatch: %s", $time, msg);
   endtask

   // Results are compared before the transaction of the same edge is
   // predicted; register writes only happen while the block is idle.
   always @(posedge clock) begin
      lookup_result_type want;
      if (reset) begin
         foreach (slot_used[i]) slot_used[i] = 1'b0;
         distinct_count = '0;
         table_size     = tdh_pkg::SIZE_W'(1024);
         expected_results.delete();
         pending_count <= 0;
      end else begin
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result strobe with no transaction outstanding");
            end else begin
               want = expected_results.pop_front();
               if (rsp_is_new !== want.is_new)
                  report_mismatch($sformatf("is_new is %0b, expected %0b",
                                            rsp_is_new, want.is_new));
               if (rsp_first_index !== want.first_index)
                  report_mismatch($sformatf("first_index is %0d, expected %0d",
                                            rsp_first_index, want.first_index));
               if (rsp_table_full !== want.table_full)
                  report_mismatch($sformatf("table_full is %0b, expected %0b",
                                            rsp_table_full, want.table_full));
            end
         end
         if (start && !busy) begin
            expected_results.push_back(insert_token(req_token_low, req_token_high,
                                                    req_start_batch));
         end
         if (csr_wr_en) table_size = csr_wr_data;
         pending_count <= expected_results.size();
      end
   end

endmodule

// ===== dv/token_dedup_hash_set_test.sv =====
// ============================================================================
// token_dedup_hash_set_test: top level of the de-duplication set testbench
// Drives directed and random token transactions across many table sizes and
// batch patterns, with and without sender gaps, while a checker beside the
// block predicts and compares every result; gives the final verdict.
// ============================================================================
`timescale 1ns / 1ps

module token_dedup_hash_set_test;

   localparam int TABLE_DEPTH  = 1024;
   localparam int TOKEN_BYTES  = 16;
   localparam int PHASES       = 30;
   localparam int PHASE_ITEMS  = 30;
   localparam int DRAIN_CYCLES = 1100;
   localparam int CYCLE_LIMIT  = 4000000;

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic [63:0]                req_token_low;
   logic [63:0]                req_token_high;
   logic                       req_start_batch;
   logic                       rsp_valid;
   logic                       rsp_is_new;
   logic [tdh_pkg::IDX_W-1:0]  rsp_first_index;
   logic                       rsp_table_full;
   logic                       csr_wr_en;
   logic [tdh_pkg::SIZE_W-1:0] csr_wr_data;
   int                         error_count;
   int                         pending_count;
   int                         cycle_count = 0;

   // Sender gap chance in percent for the current phase.
   int                         idle_pct;
   // Tokens sent in the current batch, reused to make duplicates.
   logic [127:0]               batch_tokens[$];

   token_dedup_hash_set #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .TOKEN_BYTES (TOKEN_BYTES)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_token_low   (req_token_low),
      .req_token_high  (req_token_high),
      .req_start_batch (req_start_batch),
      .rsp_valid       (rsp_valid),
      .rsp_is_new      (rsp_is_new),
      .rsp_first_index (rsp_first_index),
      .rsp_table_full  (rsp_table_full),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   token_dedup_hash_set_check #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .TOKEN_BYTES (TOKEN_BYTES)
   ) u_check (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_token_low   (req_token_low),
      .req_token_high  (req_token_high),
      .req_start_batch (req_start_batch),
      .rsp_valid       (rsp_valid),
      .rsp_is_new      (rsp_is_new),
      .rsp_first_index (rsp_first_index),
      .rsp_table_full  (rsp_table_full),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .error_count     (error_count),
      .pending_count   (pending_count)
   );

   // 2 ns clock.
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Safety net against a hung block.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Presents one token transaction and returns at the edge that takes it,
   // after an optional sender gap.
   task automatic send_token(input logic [127:0] tok, input logic new_batch);
      int gap;
      start           <= 1'b1;
      req_token_low   <= tok[63:0];
      req_token_high  <= tok[127:64];
      req_start_batch <= new_batch;
      if (new_batch) batch_tokens.delete();
      batch_tokens.push_back(tok);
      do @(posedge clock); while (busy);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         gap = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(4, 1);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Waits until every result is in and the block is idle, then writes the
   // table size register.
   task automatic set_table_size(input logic [tdh_pkg::SIZE_W-1:0] size);
      start <= 1'b0;
      do @(posedge clock); while (pending_count != 0 || busy);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= size;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Picks a token: mostly repeats and hash twins of tokens in the batch,
   // some small values that crowd the first slots, the rest fully random.
   function automatic logic [127:0] pick_token();
      int           pick;
      logic [31:0]  w;
      logic [127:0] tok;
      pick = $urandom_range(99);
      w    = $urandom;
      if (batch_tokens.size() > 0 && pick < 40) begin
         tok = batch_tokens[$urandom_range(batch_tokens.size() - 1)];
      end else if (batch_tokens.size() > 0 && pick < 60) begin
         // XOR the same word into two token words: same hash, other key.
         tok = batch_tokens[$urandom_range(batch_tokens.size() - 1)];
         case ($urandom_range(2))
            0: tok = tok ^ {64'h0, w, w};
            1: tok = tok ^ {w, w, 64'h0};
            default: tok = tok ^ {w, 32'h0, w, 32'h0};
         endcase
      end else if (pick < 70) begin
         tok = {96'h0, 32'($urandom_range(63))};
      end else begin
         tok = {$urandom, $urandom, $urandom, $urandom};
      end
      return tok;
   endfunction

   initial begin
      logic [tdh_pkg::SIZE_W-1:0] phase_sizes[16];
      logic [tdh_pkg::SIZE_W-1:0] size;
      int                         sb_pct;
      logic                       new_batch;

      phase_sizes = '{1024, 2, 16, 5, 1, 64, 3, 2047, 8, 0, 1024, 31, 4, 200, 7, 12};
      reset           = 1'b1;
      start           = 1'b0;
      req_token_low   = '0;
      req_token_high  = '0;
      req_start_batch = 1'b0;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      idle_pct        = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset size: extremes, a duplicate, and three
      // keys with the same hash that must probe past each other.
      send_token('0, 1'b1);
      send_token('1, 1'b0);
      send_token('0, 1'b0);
      send_token({64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA}, 1'b0);
      send_token({64'h0, 64'h0000_0000_0000_0001}, 1'b0);
      send_token({64'h0, 64'h0000_0001_0000_0000}, 1'b0);
      send_token({64'h0000_0001_0000_0000, 64'h0}, 1'b0);
      send_token({64'h0, 64'h0000_0001_0000_0000}, 1'b0);
      send_token({64'h8000_0000_8000_0000, 64'h8000_0000_8000_0000}, 1'b0);
      // A new batch forgets everything.
      send_token('0, 1'b1);

      // Single slot: store, repeat, then a full table.
      set_table_size(tdh_pkg::SIZE_W'(1));
      send_token({64'h1234, 64'h5678}, 1'b1);
      send_token({64'h1234, 64'h5678}, 1'b0);
      send_token({64'h9abc, 64'hdef0}, 1'b0);
      // Zero acts as one slot.
      set_table_size(tdh_pkg::SIZE_W'(0));
      send_token({64'h1234, 64'h5678}, 1'b0);
      send_token({64'h4321, 64'h8765}, 1'b0);
      // Oversized setting within the same batch: old slots stay valid.
      set_table_size(tdh_pkg::SIZE_W'(2047));
      send_token({64'h9abc, 64'hdef0}, 1'b0);
      send_token({64'h1234, 64'h5678}, 1'b0);
      // Three slots: the probe wraps to slot zero, then the table fills.
      set_table_size(tdh_pkg::SIZE_W'(3));
      send_token({64'h0, 64'h2}, 1'b1);
      send_token({64'h0, 64'h0000_0005_0000_0000}, 1'b0);
      send_token({64'h0, 64'h8}, 1'b0);
      send_token({64'h0, 64'hB}, 1'b0);

      // Random phases: alternating short and long batches, sender gaps off,
      // often and sometimes, over a spread of table sizes.
      for (int p = 0; p < PHASES; p++) begin
         if (p < 16)
            size = phase_sizes[p];
         else if ($urandom_range(3) == 0)
            size = phase_sizes[$urandom_range(15)];
         else
            size = tdh_pkg::SIZE_W'($urandom_range(48, 1));
         set_table_size(size);
         case (p % 3)
            0: idle_pct = 0;
            1: idle_pct = 53;
            default: idle_pct = 33;
         endcase
         sb_pct = (p % 2 == 1) ? 70 : 3;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i == 0)
               new_batch = ($urandom_range(99) < 75);
            else
               new_batch = ($urandom_range(99) < sb_pct);
            send_token(pick_token(), new_batch);
         end
      end

      // Drain: every result in, block idle, then a quiet stretch.
      start <= 1'b0;
      do @(posedge clock); while (pending_count != 0 || busy);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
